FILE: hw/rtl/sbrp_pkg.sv
`timescale 1ns / 1ps

package sbrp_pkg;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_SHORT     = 4'd1;
   localparam logic [3:0] ST_TYPE      = 4'd2;
   localparam logic [3:0] ST_LENGTH    = 4'd3;
   localparam logic [3:0] ST_COOKIE    = 4'd4;
   localparam logic [3:0] ST_ID        = 4'd5;
   localparam logic [3:0] ST_OVERRUN   = 4'd6;
   localparam logic [3:0] ST_TOO_SHORT = 4'd7;
   localparam logic [3:0] ST_NOT_V4    = 4'd8;
   localparam logic [3:0] ST_NOT_FOUND = 4'd9;
   localparam logic [3:0] WALK_SEARCHING = 4'd15;

   localparam logic [15:0] SUCCESS_TYPE    = 16'h0101;
   localparam logic [15:0] XOR_MAPPED_KIND = 16'h0020;
   localparam logic [31:0] MAGIC_COOKIE    = 32'h2112_a442;
   localparam logic [7:0]  FAMILY_V4       = 8'h01;
   localparam logic [16:0] HEADER_SIZE     = 17'd20;

   localparam int FAULT_TYPE   = 0;
   localparam int FAULT_COOKIE = 1;
   localparam int FAULT_ID     = 2;

   localparam logic CSR_ID_HIGH = 1'b0;
   localparam logic CSR_ID_LOW  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } beat_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [31:0] public_address;
      logic [15:0] public_port;
   } result_type;

endpackage

FILE: hw/rtl/sbrp_engine.sv
`timescale 1ns / 1ps

module sbrp_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  sbrp_pkg::beat_type     beat,
   input  logic [31:0]            id_high,
   input  logic [63:0]            id_low,
   output sbrp_pkg::result_type   result
);

   logic [16:0] byte_count_ff, byte_count_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [2:0]  header_faults_ff, header_faults_in;
   logic [31:0] byte_shift_ff, byte_shift_in;
   logic [16:0] attribute_start_ff, attribute_start_in;
   logic [3:0]  walk_outcome_ff, walk_outcome_in;
   logic [15:0] mapped_port_ff, mapped_port_in;
   logic [31:0] mapped_address_ff, mapped_address_in;

   logic [16:0] count;
   logic [31:0] shift_upd;
   logic [15:0] length_upd;
   logic [2:0]  faults_upd;
   logic [16:0] start_upd;
   logic [3:0]  walk_upd;
   logic [15:0] port_upd;
   logic [31:0] address_upd;
   logic [95:0] id_shifted;
   logic [3:0]  id_idx;
   logic [17:0] window_end;
   logic        in_window;
   logic [16:0] rel;
   logic [16:0] padded;
   logic [17:0] next_start;
   logic        length_ok;
   logic [3:0]  status;

   always_comb begin
      count = byte_count_ff;
      shift_upd = {byte_shift_ff[23:0], beat.data_byte};
      length_upd = declared_length_ff;
      faults_upd = header_faults_ff;
      start_upd = attribute_start_ff;
      walk_upd = walk_outcome_ff;
      port_upd = mapped_port_ff;
      address_upd = mapped_address_ff;

      // header checks
      id_idx = 4'(count - 17'd8);
      id_shifted = {id_high, id_low} << {id_idx, 3'b000};
      if (count == 17'd1) begin
         if (shift_upd[15:0] != sbrp_pkg::SUCCESS_TYPE) begin
            faults_upd[sbrp_pkg::FAULT_TYPE] = 1'b1;
         end
      end else if (count == 17'd3) begin
         length_upd = shift_upd[15:0];
      end else if (count == 17'd7) begin
         if (shift_upd != sbrp_pkg::MAGIC_COOKIE) begin
            faults_upd[sbrp_pkg::FAULT_COOKIE] = 1'b1;
         end
      end else if (count >= 17'd8 && count < sbrp_pkg::HEADER_SIZE) begin
         if (beat.data_byte != id_shifted[95:88]) begin
            faults_upd[sbrp_pkg::FAULT_ID] = 1'b1;
         end
      end

      // attribute walk
      window_end = {1'b0, sbrp_pkg::HEADER_SIZE} + {2'b00, declared_length_ff};
      in_window = (count >= sbrp_pkg::HEADER_SIZE) && ({1'b0, count} < window_end);
      rel = count - attribute_start_ff;
      padded = ({1'b0, shift_upd[15:0]} + 17'd3) & ~17'd3;
      next_start = {1'b0, attribute_start_ff} + 18'd4 + {1'b0, padded};
      if (in_window && walk_outcome_ff == sbrp_pkg::WALK_SEARCHING
            && count >= attribute_start_ff) begin
         case (rel)
            17'd3: begin
               if (next_start > window_end) begin
                  walk_upd = sbrp_pkg::ST_OVERRUN;
               end else if (shift_upd[31:16] != sbrp_pkg::XOR_MAPPED_KIND) begin
                  start_upd = next_start[16:0];
               end else if (shift_upd[15:0] < 16'd8) begin
                  walk_upd = sbrp_pkg::ST_TOO_SHORT;
               end
            end
            17'd5: begin
               if (beat.data_byte != sbrp_pkg::FAMILY_V4) begin
                  walk_upd = sbrp_pkg::ST_NOT_V4;
               end
            end
            17'd7: begin
               port_upd = shift_upd[15:0] ^ sbrp_pkg::MAGIC_COOKIE[31:16];
            end
            17'd11: begin
               address_upd = shift_upd ^ sbrp_pkg::MAGIC_COOKIE;
               walk_upd = sbrp_pkg::ST_OK;
            end
            default: begin
            end
         endcase
      end

      // verdict for a final byte
      length_ok = ({1'b0, count} + 18'd1)
         == ({1'b0, sbrp_pkg::HEADER_SIZE} + {2'b00, length_upd});
      if (count < 17'd19) begin
         status = sbrp_pkg::ST_SHORT;
      end else if (faults_upd[sbrp_pkg::FAULT_TYPE]) begin
         status = sbrp_pkg::ST_TYPE;
      end else if (!length_ok) begin
         status = sbrp_pkg::ST_LENGTH;
      end else if (faults_upd[sbrp_pkg::FAULT_COOKIE]) begin
         status = sbrp_pkg::ST_COOKIE;
      end else if (faults_upd[sbrp_pkg::FAULT_ID]) begin
         status = sbrp_pkg::ST_ID;
      end else if (walk_upd == sbrp_pkg::WALK_SEARCHING) begin
         status = sbrp_pkg::ST_NOT_FOUND;
      end else begin
         status = walk_upd;
      end
      result.status = status;
      result.public_address = (status == sbrp_pkg::ST_OK) ? address_upd : 32'd0;
      result.public_port = (status == sbrp_pkg::ST_OK) ? port_upd : 16'd0;

      // next state
      byte_count_in = byte_count_ff;
      declared_length_in = declared_length_ff;
      header_faults_in = header_faults_ff;
      byte_shift_in = byte_shift_ff;
      attribute_start_in = attribute_start_ff;
      walk_outcome_in = walk_outcome_ff;
      mapped_port_in = mapped_port_ff;
      mapped_address_in = mapped_address_ff;
      if (fire) begin
         if (beat.last_byte) begin
            byte_count_in = 17'd0;
            declared_length_in = 16'd0;
            header_faults_in = 3'd0;
            byte_shift_in = 32'd0;
            attribute_start_in = sbrp_pkg::HEADER_SIZE;
            walk_outcome_in = sbrp_pkg::WALK_SEARCHING;
            mapped_port_in = 16'd0;
            mapped_address_in = 32'd0;
         end else begin
            byte_count_in = (count == '1) ? count : count + 17'd1;
            declared_length_in = length_upd;
            header_faults_in = faults_upd;
            byte_shift_in = shift_upd;
            attribute_start_in = start_upd;
            walk_outcome_in = walk_upd;
            mapped_port_in = port_upd;
            mapped_address_in = address_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 17'd0;
         declared_length_ff <= 16'd0;
         header_faults_ff <= 3'd0;
         byte_shift_ff <= 32'd0;
         attribute_start_ff <= sbrp_pkg::HEADER_SIZE;
         walk_outcome_ff <= sbrp_pkg::WALK_SEARCHING;
         mapped_port_ff <= 16'd0;
         mapped_address_ff <= 32'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         declared_length_ff <= declared_length_in;
         header_faults_ff <= header_faults_in;
         byte_shift_ff <= byte_shift_in;
         attribute_start_ff <= attribute_start_in;
         walk_outcome_ff <= walk_outcome_in;
         mapped_port_ff <= mapped_port_in;
         mapped_address_ff <= mapped_address_in;
      end
   end

endmodule

FILE: hw/rtl/stun_binding_response_parser.sv
`timescale 1ns / 1ps
// a final byte is registered in the input register, then its result in the result register
// throughput: one packet byte per cycle while req_stall is low, set by the per-byte state update
// a final byte waits in the input register only while a previous result is stalled
// reset: synchronous, clears the packet state, both valid flags and
// both transaction id registers

module stun_binding_response_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_public_address,
   output logic [15:0] rsp_public_port,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0] id_high_ff, id_high_in;
   logic [63:0] id_low_ff, id_low_in;
   logic        in_valid_ff, in_valid_in;
   sbrp_pkg::beat_type beat_ff, beat_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sbrp_pkg::result_type result_ff, result_in;
   sbrp_pkg::result_type result;
   logic        csr_write;
   logic        hold;
   logic        fire;
   logic        req_accept;

   // register file
   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      id_high_in = id_high_ff;
      id_low_in = id_low_ff;
      if (csr_write) begin
         unique case (csr_paddr[3])
            sbrp_pkg::CSR_ID_HIGH: id_high_in = csr_pwdata[31:0];
            sbrp_pkg::CSR_ID_LOW:  id_low_in = csr_pwdata;
            default: begin
            end
         endcase
      end
      if (csr_paddr[2:0] != 3'd0) begin
         csr_prdata = 64'd0;
      end else if (csr_paddr[3] == sbrp_pkg::CSR_ID_HIGH) begin
         csr_prdata = {32'd0, id_high_ff};
      end else begin
         csr_prdata = id_low_ff;
      end
   end

   // input register and result register
   assign hold = in_valid_ff && beat_ff.last_byte && rsp_valid_ff && rsp_stall;
   assign fire = in_valid_ff && !hold;
   assign req_stall = in_valid_ff && hold;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = req_stall ? in_valid_ff : req_valid;
      beat_in = beat_ff;
      if (req_accept) begin
         beat_in.data_byte = req_data_byte;
         beat_in.last_byte = req_last_byte;
      end
      result_in = result_ff;
      if (fire && beat_ff.last_byte) begin
         rsp_valid_in = 1'b1;
         result_in = result;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   sbrp_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .beat    (beat_ff),
      .id_high (id_high_ff),
      .id_low  (id_low_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         id_high_ff <= 32'd0;
         id_low_ff <= 64'd0;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         id_high_ff <= id_high_in;
         id_low_ff <= id_low_in;
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      beat_ff <= beat_in;
      result_ff <= result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = result_ff.status;
   assign rsp_public_address = result_ff.public_address;
   assign rsp_public_port = result_ff.public_port;

   // a processed final byte always lands in the result register
   a_last_gives_result : assert property (@(posedge clock) disable iff (reset)
      (fire && beat_ff.last_byte) |=> rsp_valid_ff)
      else $error("final byte processed without a result");

   // only a pending final byte behind a stalled result holds the input side
   a_stall_reason : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && beat_ff.last_byte && rsp_valid_ff))
      else $error("input stalled without a waiting result");

   // address and port are only reported for a successful parse
   a_fields_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.status != sbrp_pkg::ST_OK)
         |-> (result_ff.public_address == 32'd0 && result_ff.public_port == 16'd0))
      else $error("address reported for a failed parse");

endmodule

FILE: dv/stun_result_checker.sv
`timescale 1ns / 1ps

module stun_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [31:0] rsp_public_address,
   input  logic [15:0] rsp_public_port,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          failures,
   output int          results_due
);

   logic [31:0] id_high;
   logic [63:0] id_low;

   logic [16:0] byte_count;
   logic [15:0] declared_length;
   logic [2:0]  header_faults;
   logic [31:0] byte_shift;
   logic [16:0] attr_start;
   logic [15:0] attr_kind;
   logic [15:0] attr_len;
   logic [3:0]  walk_state;
   logic [15:0] mapped_port;
   logic [31:0] mapped_address;

   sbrp_pkg::result_type parsed_results[$];

   task automatic restart_packet();
      byte_count = '0;
      declared_length = '0;
      header_faults = '0;
      byte_shift = '0;
      attr_start = sbrp_pkg::HEADER_SIZE;
      attr_kind = '0;
      attr_len = '0;
      walk_state = sbrp_pkg::WALK_SEARCHING;
      mapped_port = '0;
      mapped_address = '0;
   endtask

   function automatic logic [7:0] id_byte(input int c);
      if (c < 12)
         return 8'(id_high >> (8 * (11 - c)));
      return 8'(id_low >> (8 * (19 - c)));
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic last);
      int c;
      int rel;
      int next_start;
      int size;
      logic [3:0] verdict;
      sbrp_pkg::result_type r;
      c = byte_count;
      byte_shift = {byte_shift[23:0], b};

      if (c == 1 && byte_shift[15:0] != sbrp_pkg::SUCCESS_TYPE)
         header_faults[sbrp_pkg::FAULT_TYPE] = 1'b1;
      else if (c == 3)
         declared_length = byte_shift[15:0];
      else if (c == 7 && byte_shift != sbrp_pkg::MAGIC_COOKIE)
         header_faults[sbrp_pkg::FAULT_COOKIE] = 1'b1;
      else if (c >= 8 && c < sbrp_pkg::HEADER_SIZE && b != id_byte(c))
         header_faults[sbrp_pkg::FAULT_ID] = 1'b1;

      // attribute walk, only inside the declared length and until decided
      if (c >= sbrp_pkg::HEADER_SIZE && c < sbrp_pkg::HEADER_SIZE + declared_length
          && walk_state == sbrp_pkg::WALK_SEARCHING && c >= attr_start) begin
         rel = c - attr_start;
         if (rel == 3) begin
            attr_kind = byte_shift[31:16];
            attr_len = byte_shift[15:0];
            next_start = attr_start + 4 + ((attr_len + 3) & ~3);
            if (next_start > sbrp_pkg::HEADER_SIZE + declared_length)
               walk_state = sbrp_pkg::ST_OVERRUN;
            else if (attr_kind != sbrp_pkg::XOR_MAPPED_KIND)
               attr_start = 17'(next_start);
            else if (attr_len < 8)
               walk_state = sbrp_pkg::ST_TOO_SHORT;
         end else if (rel == 5 && b != sbrp_pkg::FAMILY_V4) begin
            walk_state = sbrp_pkg::ST_NOT_V4;
         end else if (rel == 7) begin
            mapped_port = byte_shift[15:0] ^ sbrp_pkg::MAGIC_COOKIE[31:16];
         end else if (rel == 11) begin
            mapped_address = byte_shift ^ sbrp_pkg::MAGIC_COOKIE;
            walk_state = sbrp_pkg::ST_OK;
         end
      end

      if (byte_count != '1)
         byte_count++;

      if (last) begin
         size = c + 1;
         if (size < sbrp_pkg::HEADER_SIZE)
            verdict = sbrp_pkg::ST_SHORT;
         else if (header_faults[sbrp_pkg::FAULT_TYPE])
            verdict = sbrp_pkg::ST_TYPE;
         else if (size != sbrp_pkg::HEADER_SIZE + declared_length)
            verdict = sbrp_pkg::ST_LENGTH;
         else if (header_faults[sbrp_pkg::FAULT_COOKIE])
            verdict = sbrp_pkg::ST_COOKIE;
         else if (header_faults[sbrp_pkg::FAULT_ID])
            verdict = sbrp_pkg::ST_ID;
         else if (walk_state == sbrp_pkg::WALK_SEARCHING)
            verdict = sbrp_pkg::ST_NOT_FOUND;
         else
            verdict = walk_state;
         r.status = verdict;
         r.public_address = (verdict == sbrp_pkg::ST_OK) ? mapped_address : '0;
         r.public_port = (verdict == sbrp_pkg::ST_OK) ? mapped_port : '0;
         parsed_results.push_back(r);
         restart_packet();
      end
   endtask

   task automatic report(input bit unexpected, input sbrp_pkg::result_type want,
                         input sbrp_pkg::result_type got);
      failures++;
      if (failures <= 10) begin
         if (unexpected)
            $display("unexpected result: status %0d address %h port %h",
                     got.status, got.public_address, got.public_port);
         else
            $display("mismatch: expected status %0d address %h port %h, got %0d %h %h",
                     want.status, want.public_address, want.public_port,
                     got.status, got.public_address, got.public_port);
      end
   endtask

   always @(posedge clock) begin
      sbrp_pkg::result_type got;
      sbrp_pkg::result_type want;
      if (reset) begin
         id_high = '0;
         id_low = '0;
         parsed_results.delete();
         failures = 0;
         restart_packet();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == {sbrp_pkg::CSR_ID_HIGH, 3'b000})
               id_high = csr_pwdata[31:0];
            else if (csr_paddr == {sbrp_pkg::CSR_ID_LOW, 3'b000})
               id_low = csr_pwdata;
         end
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_public_address, rsp_public_port};
            if (parsed_results.size() == 0) begin
               report(1'b1, got, got);
            end else begin
               want = parsed_results.pop_front();
               if (got.status !== want.status || got.public_address !== want.public_address
                   || got.public_port !== want.public_port)
                  report(1'b0, want, got);
            end
         end
         if (req_valid && !req_stall)
            parse_byte(req_data_byte, req_last_byte);
      end
      results_due = parsed_results.size();
   end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int QUIET_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BYTES = 1250;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = '0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_status;
   logic [31:0] rsp_public_address;
   logic [15:0] rsp_public_port;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int failures;
   int results_due;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   int idle_plan[4] = '{0, 58, 0, 23};
   int stall_plan[4] = '{0, 0, 58, 23};

   logic [31:0] id_hi_now = '0;
   logic [63:0] id_lo_now = '0;
   logic [7:0]  attrs[$];
   logic [7:0]  frame[$];

   stun_binding_response_parser u_dut (.*);

   stun_result_checker u_checker (.*);

   always #2 clock = ~clock;

   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   // any transaction on the request or response channel counts as progress
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_frame();
      foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (results_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_id(input logic [31:0] hi, input logic [63:0] lo);
      csr_write({sbrp_pkg::CSR_ID_HIGH, 3'b000}, {32'h0, hi});
      csr_write({sbrp_pkg::CSR_ID_LOW, 3'b000}, lo);
      id_hi_now = hi;
      id_lo_now = lo;
   endtask

   function automatic logic [47:0] rand48();
      return {16'($urandom_range(0, 65535)), $urandom};
   endfunction

   function automatic logic [15:0] other_kind();
      logic [15:0] k;
      k = 16'($urandom_range(0, 65535));
      if (k == sbrp_pkg::XOR_MAPPED_KIND)
         k = ~k;
      return k;
   endfunction

   // attribute bytes; for a mapped-address attribute the payload gives port and address
   task automatic add_attr(input logic [15:0] kind, input int len, input logic [7:0] family,
                           input logic [47:0] payload);
      int padded;
      padded = ((len + 3) / 4) * 4;
      attrs.push_back(kind[15:8]);
      attrs.push_back(kind[7:0]);
      attrs.push_back(len[15:8]);
      attrs.push_back(len[7:0]);
      for (int i = 0; i < padded; i++) begin
         if (kind == sbrp_pkg::XOR_MAPPED_KIND && i == 1)
            attrs.push_back(family);
         else if (kind == sbrp_pkg::XOR_MAPPED_KIND && i >= 2 && i < 8)
            attrs.push_back(payload[47 - 8 * (i - 2) -: 8]);
         else
            attrs.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic emit_frame(input logic [15:0] msg_type, input int declared,
                             input logic [31:0] cookie, input logic [95:0] id);
      frame.delete();
      frame.push_back(msg_type[15:8]);
      frame.push_back(msg_type[7:0]);
      frame.push_back(declared[15:8]);
      frame.push_back(declared[7:0]);
      for (int i = 3; i >= 0; i--) frame.push_back(cookie[8 * i +: 8]);
      for (int i = 11; i >= 0; i--) frame.push_back(id[8 * i +: 8]);
      foreach (attrs[i]) frame.push_back(attrs[i]);
   endtask

   task automatic emit_clean();
      emit_frame(sbrp_pkg::SUCCESS_TYPE, attrs.size(), sbrp_pkg::MAGIC_COOKIE,
                 {id_hi_now, id_lo_now});
   endtask

   task automatic random_frame();
      int pick;
      int len;
      int declared;
      logic [7:0] fam;
      logic [15:0] msg_type;
      logic [31:0] cookie;
      logic [95:0] id;
      attrs.delete();
      repeat ($urandom_range(0, 2)) add_attr(other_kind(), $urandom_range(0, 12), 8'h00, '0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         add_attr(sbrp_pkg::XOR_MAPPED_KIND, $urandom_range(8, 12), sbrp_pkg::FAMILY_V4,
                  rand48());
         repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 3) == 0)
               add_attr(sbrp_pkg::XOR_MAPPED_KIND, $urandom_range(0, 12),
                        8'($urandom_range(0, 2)), rand48());
            else
               add_attr(other_kind(), $urandom_range(0, 12), 8'h00, '0);
         end
      end else if (pick < 58) begin
         add_attr(sbrp_pkg::XOR_MAPPED_KIND, $urandom_range(0, 7), sbrp_pkg::FAMILY_V4,
                  rand48());
      end else if (pick < 66) begin
         fam = 8'($urandom_range(0, 254));
         if (fam >= sbrp_pkg::FAMILY_V4)
            fam++;
         add_attr(sbrp_pkg::XOR_MAPPED_KIND, $urandom_range(8, 12), fam, rand48());
      end else if (pick < 76) begin
         repeat ($urandom_range(0, 3)) attrs.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
         len = $urandom_range(1, 40);
         add_attr($urandom_range(0, 1) ? sbrp_pkg::XOR_MAPPED_KIND : other_kind(), len,
                  sbrp_pkg::FAMILY_V4, rand48());
         repeat ($urandom_range(1, ((len + 3) / 4) * 4)) void'(attrs.pop_back());
      end else begin
         attrs.delete();
         repeat ($urandom_range(0, 24)) attrs.push_back(8'($urandom_range(0, 255)));
      end

      declared = attrs.size();
      msg_type = sbrp_pkg::SUCCESS_TYPE;
      cookie = sbrp_pkg::MAGIC_COOKIE;
      id = {id_hi_now, id_lo_now};
      if ($urandom_range(0, 99) < 6)
         msg_type = 16'($urandom_range(0, 65535));
      if ($urandom_range(0, 99) < 6)
         cookie ^= 32'h1 << $urandom_range(0, 31);
      if ($urandom_range(0, 99) < 6)
         id ^= 96'h1 << $urandom_range(0, 95);
      if ($urandom_range(0, 99) < 5)
         declared += $urandom_range(1, 8);
      emit_frame(msg_type, declared, cookie, id);
      if ($urandom_range(0, 99) < 5)
         repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 99) < 5)
         frame = frame[0:$urandom_range(0, 18)];
   endtask

   initial begin
      int random_bytes;
      random_bytes = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // id registers at their reset value
      attrs.delete();
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 8, sbrp_pkg::FAMILY_V4, rand48());
      emit_clean();
      send_frame();
      drain();
      set_id('1, '0);

      // short packets
      frame = {8'h5a};
      send_frame();
      attrs.delete();
      emit_clean();
      frame = frame[0:18];
      send_frame();
      // header only, nothing to find
      emit_clean();
      send_frame();
      // header faults
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 8, sbrp_pkg::FAMILY_V4, rand48());
      emit_frame(~sbrp_pkg::SUCCESS_TYPE, attrs.size(), sbrp_pkg::MAGIC_COOKIE,
                 {id_hi_now, id_lo_now});
      send_frame();
      emit_clean();
      frame.push_back(8'h00);
      send_frame();
      emit_frame(sbrp_pkg::SUCCESS_TYPE, attrs.size() + 4, sbrp_pkg::MAGIC_COOKIE,
                 {id_hi_now, id_lo_now});
      send_frame();
      emit_frame(sbrp_pkg::SUCCESS_TYPE, attrs.size(), ~sbrp_pkg::MAGIC_COOKIE,
                 {id_hi_now, id_lo_now});
      send_frame();
      emit_frame(sbrp_pkg::SUCCESS_TYPE, attrs.size(), sbrp_pkg::MAGIC_COOKIE,
                 {id_hi_now, id_lo_now} ^ 96'h1);
      send_frame();
      // overrun on the largest attribute length
      attrs.delete();
      add_attr(other_kind(), 16'hffff, 8'h00, '0);
      attrs = attrs[0:7];
      emit_clean();
      send_frame();
      // mapped address too short, and not ipv4
      attrs.delete();
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 0, sbrp_pkg::FAMILY_V4, '0);
      emit_clean();
      send_frame();
      attrs.delete();
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 7, sbrp_pkg::FAMILY_V4, rand48());
      emit_clean();
      send_frame();
      attrs.delete();
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 8, 8'h02, rand48());
      emit_clean();
      send_frame();
      // decoded port and address at zero and all ones
      attrs.delete();
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 8, sbrp_pkg::FAMILY_V4,
               {sbrp_pkg::MAGIC_COOKIE[31:16], sbrp_pkg::MAGIC_COOKIE});
      emit_clean();
      send_frame();
      attrs.delete();
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 8, sbrp_pkg::FAMILY_V4,
               ~{sbrp_pkg::MAGIC_COOKIE[31:16], sbrp_pkg::MAGIC_COOKIE});
      emit_clean();
      send_frame();
      // found after another attribute, a later one ignored
      attrs.delete();
      add_attr(other_kind(), 5, 8'h00, '0);
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 12, sbrp_pkg::FAMILY_V4, rand48());
      add_attr(sbrp_pkg::XOR_MAPPED_KIND, 8, 8'h02, rand48());
      emit_clean();
      send_frame();
      // incomplete attribute header at the end
      attrs.delete();
      add_attr(other_kind(), 4, 8'h00, '0);
      repeat (3) attrs.push_back(8'($urandom_range(0, 255)));
      emit_clean();
      send_frame();
      attrs.delete();
      frame.delete();

      for (int p = 0; p < 4; p++) begin
         drain();
         case (p)
            0: set_id('0, '1);
            3: set_id('1, {$urandom, $urandom});
            default: set_id($urandom, {$urandom, $urandom});
         endcase
         idle_pct = idle_plan[p];
         stall_pct = stall_plan[p];
         while (random_bytes < RANDOM_BYTES * (p + 1) / 4) begin
            random_frame();
            random_bytes += frame.size();
            send_frame();
         end
      end
      drain();

      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
